[hw/rtl/fgd_pkg.sv]
`default_nettype none

package fgd_pkg;

  // event kinds carried by req_type
  localparam logic [2:0] REQ_CALL    = 3'd0;
  localparam logic [2:0] REQ_ALARM   = 3'd1;
  localparam logic [2:0] REQ_DISPLAY = 3'd2;
  localparam logic [2:0] REQ_ORIENT  = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  // state codes
  localparam logic [2:0] VAL_ON       = 3'd1;
  localparam logic [2:0] ALARM_RING   = 3'd1;
  localparam logic [2:0] ALARM_SHOWN  = 3'd2;
  localparam logic [2:0] ORI_UNDEF    = 3'd0;
  localparam logic [2:0] ORI_UP       = 3'd1;
  localparam logic [2:0] ORI_DOWN     = 3'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 1'd1;

  localparam int unsigned DELAY_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

  typedef struct packed {
    logic               call_ringing;
    logic               alarm_active;
    logic               display_on;
    logic [2:0]         orient_raw;
    logic [2:0]         orient_effective;
    logic               primed;
    logic [DELAY_W-1:0] delay_left;
    logic               delay_running;
  } state_t;

  typedef struct packed {
    logic enabled;
    logic [DELAY_W-1:0] delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic primed;
    logic alarm_pulse;
    logic call_pulse;
  } eval_t;

  // priming and flip decision on the current state
  function automatic eval_t evaluate(state_t s, logic enabled);
    eval_t r;
    r.primed      = s.primed;
    r.alarm_pulse = 1'b0;
    r.call_pulse  = 1'b0;
    if (!s.display_on || (!s.alarm_active && !s.call_ringing) ||
        s.orient_raw == ORI_UNDEF || s.orient_effective == ORI_UNDEF) begin
      r.primed = 1'b0;
    end else if (s.orient_effective == ORI_UP) begin
      r.primed = 1'b1;
    end else if (s.orient_effective == ORI_DOWN && s.primed) begin
      r.primed      = 1'b0;
      r.alarm_pulse = enabled & s.alarm_active;
      r.call_pulse  = enabled & s.call_ringing;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fgd_next.sv]
`default_nettype none

// next state and flip pulses for one event
module fgd_next (
  input  wire logic [2:0]      req_type,
  input  wire logic [2:0]      state_value,
  input  wire fgd_pkg::state_t st,
  input  wire fgd_pkg::cfg_t   cfg,
  output fgd_pkg::state_t      st_next,
  output logic                 alarm_pulse,
  output logic                 call_pulse
);

  fgd_pkg::state_t nx;
  fgd_pkg::eval_t  ev_a;
  fgd_pkg::eval_t  ev_b;
  logic            flag_val;
  logic [2:0]      prev_raw;

  always_comb begin
    nx       = st;
    ev_a     = '0;
    ev_b     = '0;
    flag_val = 1'b0;
    prev_raw = st.orient_raw;
    unique case (req_type)
      fgd_pkg::REQ_CALL: begin
        flag_val = (state_value == fgd_pkg::VAL_ON);
        if (nx.call_ringing != flag_val) begin
          nx.call_ringing = flag_val;
          ev_a = fgd_pkg::evaluate(nx, cfg.enabled);
          nx.primed = ev_a.primed;
        end
      end
      fgd_pkg::REQ_ALARM: begin
        flag_val = (state_value == fgd_pkg::ALARM_RING) ||
                   (state_value == fgd_pkg::ALARM_SHOWN);
        if (nx.alarm_active != flag_val) begin
          nx.alarm_active = flag_val;
          ev_a = fgd_pkg::evaluate(nx, cfg.enabled);
          nx.primed = ev_a.primed;
        end
      end
      fgd_pkg::REQ_DISPLAY: begin
        flag_val = (state_value == fgd_pkg::VAL_ON);
        if (nx.display_on != flag_val) begin
          nx.display_on = flag_val;
          ev_a = fgd_pkg::evaluate(nx, cfg.enabled);
          nx.primed = ev_a.primed;
        end
      end
      fgd_pkg::REQ_ORIENT: begin
        if (state_value != nx.orient_raw) begin
          nx.orient_raw = state_value;
          ev_a = fgd_pkg::evaluate(nx, cfg.enabled);
          nx.primed        = ev_a.primed;
          nx.delay_running = 1'b0;
          nx.delay_left    = '0;
          // face-up straight after undefined waits out the delay
          if (prev_raw == fgd_pkg::ORI_UNDEF && state_value == fgd_pkg::ORI_UP) begin
            nx.orient_effective = fgd_pkg::ORI_UNDEF;
            nx.delay_left = (cfg.delay_ticks == '0) ? fgd_pkg::DELAY_W'(1)
                                                    : cfg.delay_ticks;
            nx.delay_running = 1'b1;
          end else if (nx.orient_effective != nx.orient_raw) begin
            nx.orient_effective = nx.orient_raw;
            ev_b = fgd_pkg::evaluate(nx, cfg.enabled);
            nx.primed = ev_b.primed;
          end
        end
      end
      fgd_pkg::REQ_TICK: begin
        if (nx.delay_running) begin
          if (nx.delay_left > fgd_pkg::DELAY_W'(1)) begin
            nx.delay_left = nx.delay_left - fgd_pkg::DELAY_W'(1);
          end else begin
            nx.delay_left    = '0;
            nx.delay_running = 1'b0;
            if (nx.orient_effective != nx.orient_raw) begin
              nx.orient_effective = nx.orient_raw;
              ev_b = fgd_pkg::evaluate(nx, cfg.enabled);
              nx.primed = ev_b.primed;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign st_next     = nx;
  assign alarm_pulse = ev_a.alarm_pulse | ev_b.alarm_pulse;
  assign call_pulse  = ev_a.call_pulse | ev_b.call_pulse;

endmodule

`default_nettype wire

[hw/rtl/flipover_gesture_detector.sv]
`default_nettype none

// channel  | handshake                   | payload
// ---------+-----------------------------+--------------------------
// in       | in_valid / in_stall         | req_type, state_value
// out      | out_valid / out_stall       | alarm_flip, call_flip
// cfg      | cfg_we                      | cfg_index, cfg_data
//
// One event per cycle while in_stall is low: the event updates the
// state in the cycle it is taken and its result sits in the output
// register on the next cycle. Every event gives exactly one result.
// in_stall rises only while the output register is full and stalled.
// Synchronous reset clears the state and out_valid (the flip bits are
// not reset) and loads the config defaults.
module flipover_gesture_detector (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [2:0]                   req_type,
  input  wire logic [2:0]                   state_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              alarm_flip,
  output logic                              call_flip,
  input  wire logic                         cfg_we,
  input  wire logic [fgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fgd_pkg::DELAY_W-1:0]  cfg_data
);

  fgd_pkg::state_t st;
  fgd_pkg::state_t st_next;
  fgd_pkg::cfg_t   cfg;
  logic            alarm_pulse;
  logic            call_pulse;
  logic            accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  fgd_next u_next (
    .req_type    (req_type),
    .state_value (state_value),
    .st          (st),
    .cfg         (cfg),
    .st_next     (st_next),
    .alarm_pulse (alarm_pulse),
    .call_pulse  (call_pulse)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled     <= 1'b1;
      cfg.delay_ticks <= fgd_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fgd_pkg::CFG_ENABLED: cfg.enabled     <= cfg_data[0];
        fgd_pkg::CFG_DELAY:   cfg.delay_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alarm_flip <= alarm_pulse;
      call_flip  <= call_pulse;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fgd_checker.sv]
`default_nettype none

module fgd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [2:0] req_type,
  input wire logic [2:0] state_value,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       alarm_flip,
  input wire logic       call_flip
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // input backs up only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // each transfer in gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("missing result after input transfer");

  // unknown events and display-off never flip
  a_no_flip: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall &&
     (req_type > fgd_pkg::REQ_TICK ||
      (req_type == fgd_pkg::REQ_DISPLAY && state_value != fgd_pkg::VAL_ON)))
    |=> (!alarm_flip && !call_flip))
    else $error("flip on an event that cannot flip");

endmodule

bind flipover_gesture_detector fgd_checker u_fgd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .req_type    (req_type),
  .state_value (state_value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .alarm_flip  (alarm_flip),
  .call_flip   (call_flip)
);

`default_nettype wire
